@@ hdl/arcade_bus_decoder_assert.svh @@
// Assertion macros for the arcade bus decoder RTL.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef ARCADE_BUS_DECODER_ASSERT_SVH
`define ARCADE_BUS_DECODER_ASSERT_SVH

// Check a property on every rising edge, skipping cycles in reset.
`define ABD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ABD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/abd_pkg.sv @@
// Shared types and constants of the arcade bus decoder.
// Depends on nothing; imported by every module of the block.
package abd_pkg;

   // default sizes of the memory map
   localparam int ROM_BYTES_DEFAULT      = 16384;
   localparam int PAGE_BYTES_DEFAULT     = 4096;
   localparam int VRAM_TILES_DEFAULT     = 1024;
   localparam int BG_VRAM_OFFSET_DEFAULT = 2048;

   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

   // address windows, compared on bits [15:12] or [15:11]
   localparam logic [3:0] WIN_RAM     = 4'h4;
   localparam logic [4:0] WIN_VIDEO   = 5'b01010;
   localparam logic [4:0] WIN_SCROLL  = 5'b01011;
   localparam logic [4:0] WIN_BUTTONS = 5'b01110;
   localparam logic [4:0] WIN_SWITCH  = 5'b01111;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_LOAD  = 2'd2,
      MODE_TAKE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_ROM  = 2'd1,
      SRC_RAM  = 2'd2,
      SRC_PORT = 2'd3
   } src_type;

   // access strobe of a byte memory
   typedef struct packed {
      logic en;
      logic we;
   } mem_ctl_type;

   // access strobe of the dirty-flag map
   typedef struct packed {
      logic en;
      logic we;
      logic wbit;
   } tile_ctl_type;

endpackage

@@ hdl/arcade_bus_decoder.sv @@
// Top level of the arcade bus decoder: address decode, video/scroll registers,
// access and result stages. Depends on abd_pkg, abd_spram, abd_dirty_map and
// the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req     | in        | req_tvalid/req_tready | req_tuser mode, req_tdata access
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata result
//
// Flow: an item issues its memory access in the cycle it is accepted; the
// access stage holds it with its memory read data and passes the result on
// to the output register. A new item can be taken every cycle unless a
// stalled result or the dirty-map sweep holds req_tready low. Each memory
// (program ROM, work RAM, dirty map) has a single read/write port, and a
// take-and-clear reads and clears in one access. Reset: synchronous, active
// high. After reset the dirty map sweeps all VRAM_TILES entries to one, one
// per cycle; req_tready stays low until the sweep is done.
// Stalls: a result that waits on rsp_tready holds the access stage; the
// access stage holds the memory read data, and req_tready drops until the
// result register frees.
module arcade_bus_decoder #(
   parameter int ROM_BYTES      = abd_pkg::ROM_BYTES_DEFAULT,
   parameter int PAGE_BYTES     = abd_pkg::PAGE_BYTES_DEFAULT,
   parameter int VRAM_TILES     = abd_pkg::VRAM_TILES_DEFAULT,
   parameter int BG_VRAM_OFFSET = abd_pkg::BG_VRAM_OFFSET_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // address[15:0], write_data[23:16],
                                   // button_lines[31:24], switch_lines[39:32]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data[7:0], dirty_flag[8], page_select[9],
                                   // palette_select[10], scroll_value[18:11], zero above
);
   import abd_pkg::*;
   `include "arcade_bus_decoder_assert.svh"

   localparam int ROM_AW   = $clog2(ROM_BYTES);
   localparam int PAGE_AW  = $clog2(PAGE_BYTES);
   localparam int RAM_AW   = PAGE_AW + 1;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   localparam int TILE_AW  = $clog2(VRAM_TILES);

   localparam logic [16:0] ROM_LIMIT  = 17'(ROM_BYTES);
   localparam logic [12:0] PAGE_LIMIT = 13'(PAGE_BYTES);
   localparam logic [16:0] TILE_LIMIT = 17'(VRAM_TILES);
   localparam logic [13:0] BG_LO      = 14'(BG_VRAM_OFFSET);
   localparam logic [13:0] BG_HI      = 14'(BG_VRAM_OFFSET + VRAM_TILES);

   // request fields
   mode_type    req_mode;
   logic [15:0] req_address;
   logic [7:0]  req_write_data;
   logic [7:0]  req_buttons;
   logic [7:0]  req_switches;

   assign req_mode       = mode_type'(req_tuser);
   assign req_address    = req_tdata[15:0];
   assign req_write_data = req_tdata[23:16];
   assign req_buttons    = req_tdata[31:24];
   assign req_switches   = req_tdata[39:32];

   // decode
   logic        accept;
   logic        out_free;
   logic        tiles_ready;
   logic [11:0] ram_offset;
   logic [13:0] ram_offset_wide;
   logic [13:0] tile_offset;
   logic        rom_hit;
   logic        ram_window;
   logic        ram_hit;
   logic        vram_hit;
   logic        take_hit;
   logic        video_hit;
   logic        scroll_hit;
   logic        buttons_hit;
   logic        switch_hit;

   assign ram_offset      = req_address[11:0];
   assign ram_offset_wide = {2'b00, ram_offset};
   assign tile_offset     = ram_offset_wide - BG_LO;
   assign rom_hit     = {1'b0, req_address} < ROM_LIMIT;
   assign ram_window  = req_address[15:12] == WIN_RAM;
   assign ram_hit     = ram_window && ({1'b0, ram_offset} < PAGE_LIMIT);
   assign vram_hit    = ram_offset_wide >= BG_LO && ram_offset_wide < BG_HI;
   assign take_hit    = {1'b0, req_address} < TILE_LIMIT;
   assign video_hit   = req_address[15:11] == WIN_VIDEO;
   assign scroll_hit  = req_address[15:11] == WIN_SCROLL;
   assign buttons_hit = req_address[15:11] == WIN_BUTTONS;
   assign switch_hit  = req_address[15:11] == WIN_SWITCH;

   // video and scroll registers
   logic       page_ff;
   logic       page_in;
   logic       palette_ff;
   logic       palette_in;
   logic [7:0] scroll_ff;
   logic [7:0] scroll_in;

   // access stage
   logic       s1_valid_ff;
   logic       s1_valid_in;
   mode_type   s1_mode_ff;
   src_type    s1_src_ff;
   src_type    src_sel;
   logic [7:0] s1_port_ff;
   logic [7:0] port_byte;
   logic       s1_take_ff;
   logic       s1_page_ff;
   logic       s1_palette_ff;
   logic [7:0] s1_scroll_ff;

   // result stage
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_read_ff;
   logic [7:0] rsp_read_in;
   logic       rsp_dirty_ff;
   logic       rsp_dirty_in;
   logic       rsp_page_ff;
   logic       rsp_palette_ff;
   logic [7:0] rsp_scroll_ff;

   // memory ports
   mem_ctl_type        rom_ctl;
   mem_ctl_type        ram_ctl;
   tile_ctl_type       tile_ctl;
   logic [RAM_AW-1:0]  ram_addr;
   logic [TILE_AW-1:0] tile_addr;
   logic [7:0]         rom_rd_data;
   logic [7:0]         ram_rd_data;
   logic               tile_rd_bit;

   // take an item when the dirty map is ready and the access stage is empty or drains this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = tiles_ready && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   // memory strobes; only an accepted item touches a memory
   always_comb begin
      rom_ctl.en  = accept && rom_hit &&
                    (req_mode == MODE_READ || req_mode == MODE_LOAD);
      rom_ctl.we  = req_mode == MODE_LOAD;
      ram_ctl.en  = accept && ram_hit &&
                    (req_mode == MODE_READ || req_mode == MODE_WRITE);
      ram_ctl.we  = req_mode == MODE_WRITE;
      ram_addr    = {page_ff, ram_offset[PAGE_AW-1:0]};
      tile_ctl.en   = 1'b0;
      tile_ctl.we   = 1'b1;
      tile_ctl.wbit = 1'b0;
      tile_addr     = req_address[TILE_AW-1:0];
      if (req_mode == MODE_TAKE) begin
         tile_ctl.en = accept && take_hit;
      end else if (req_mode == MODE_WRITE) begin
         // mark the tile behind a background VRAM write
         tile_ctl.en   = accept && ram_hit && vram_hit;
         tile_ctl.wbit = 1'b1;
         tile_addr     = tile_offset[TILE_AW-1:0];
      end
   end

   // register writes take effect at accept; later items see the new page
   always_comb begin
      page_in    = page_ff;
      palette_in = palette_ff;
      scroll_in  = scroll_ff;
      if (accept && req_mode == MODE_WRITE) begin
         if (video_hit) begin
            page_in    = req_write_data[0];
            palette_in = req_write_data[1];
         end else if (scroll_hit) begin
            scroll_in = req_write_data;
         end
      end
   end

   // read source; non-reads answer the unmapped byte
   always_comb begin
      src_sel   = SRC_NONE;
      port_byte = req_buttons;
      if (req_mode == MODE_READ) begin
         priority if (rom_hit) begin
            src_sel = SRC_ROM;
         end else if (ram_hit) begin
            src_sel = SRC_RAM;
         end else if (buttons_hit) begin
            src_sel = SRC_PORT;
         end else if (switch_hit) begin
            src_sel   = SRC_PORT;
            port_byte = req_switches;
         end else begin
            src_sel = SRC_NONE;
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !out_free);

   always_comb begin
      unique case (s1_src_ff)
         SRC_ROM:  rsp_read_in = rom_rd_data;
         SRC_RAM:  rsp_read_in = ram_rd_data;
         SRC_PORT: rsp_read_in = s1_port_ff;
         SRC_NONE: rsp_read_in = UNMAPPED_BYTE;
      endcase
      if (s1_mode_ff != MODE_READ) begin
         rsp_read_in = UNMAPPED_BYTE;
      end
      rsp_dirty_in = (s1_mode_ff == MODE_TAKE) && s1_take_ff && tile_rd_bit;
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= 1'b0;
         palette_ff   <= 1'b0;
         scroll_ff    <= 8'h00;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         page_ff      <= page_in;
         palette_ff   <= palette_in;
         scroll_ff    <= scroll_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // access stage payload: snapshot registers as they stand after this item
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff    <= req_mode;
         s1_src_ff     <= src_sel;
         s1_port_ff    <= port_byte;
         s1_take_ff    <= take_hit;
         s1_page_ff    <= page_in;
         s1_palette_ff <= palette_in;
         s1_scroll_ff  <= scroll_in;
      end
   end

   // result stage payload
   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_read_ff    <= rsp_read_in;
         rsp_dirty_ff   <= rsp_dirty_in;
         rsp_page_ff    <= s1_page_ff;
         rsp_palette_ff <= s1_palette_ff;
         rsp_scroll_ff  <= s1_scroll_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_scroll_ff, rsp_palette_ff, rsp_page_ff,
                        rsp_dirty_ff, rsp_read_ff};

   abd_spram #(
      .DEPTH (ROM_BYTES),
      .WIDTH (8)
   ) u_rom (
      .clock   (clock),
      .ctl     (rom_ctl),
      .addr    (req_address[ROM_AW-1:0]),
      .wr_data (req_write_data),
      .rd_data (rom_rd_data)
   );

   abd_spram #(
      .DEPTH (RAM_DEPTH),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .addr    (ram_addr),
      .wr_data (req_write_data),
      .rd_data (ram_rd_data)
   );

   abd_dirty_map #(
      .TILES (VRAM_TILES)
   ) u_dirty (
      .clock  (clock),
      .reset  (reset),
      .ctl    (tile_ctl),
      .addr   (tile_addr),
      .rd_bit (tile_rd_bit),
      .ready  (tiles_ready)
   );

   // no item may enter while the dirty map is still sweeping
   `ABD_ASSERT(a_accept_after_sweep, clock, reset, accept |-> tiles_ready, "item accepted during dirty-map sweep")
   // an accepted item always occupies the access stage next cycle
   `ABD_ASSERT(a_accept_lands, clock, reset, accept |=> s1_valid_ff, "accepted item lost before access stage")
   // a stalled access stage keeps its item
   `ABD_ASSERT(a_stall_holds, clock, reset, (s1_valid_ff && !out_free) |=> s1_valid_ff, "stalled item dropped")
   // only reads pick a data source; a reported dirty flag comes with the unmapped byte
   `ABD_ASSERT(a_src_from_read, clock, reset, (s1_valid_ff && s1_src_ff != SRC_NONE) |-> (s1_mode_ff == MODE_READ), "read source set on a non-read item")
   `ABD_ASSERT(a_dirty_from_take, clock, reset, (rsp_valid_ff && rsp_dirty_ff) |-> (rsp_read_ff == UNMAPPED_BYTE), "dirty flag with read data")

endmodule

@@ hdl/abd_spram.sv @@
// Single-port synchronous byte memory, read-first, with a registered read.
// Depends on abd_pkg for the access strobe type.
module abd_spram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  abd_pkg::mem_ctl_type     ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   import abd_pkg::*;

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read old contents, write in the same cycle
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         rd_data_ff <= mem_array[addr];
         if (ctl.we) begin
            mem_array[addr] <= wr_data;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/abd_dirty_map.sv @@
// Background tile dirty flags: one-bit memory with a set-all sweep after reset.
// Depends on abd_pkg for the access strobe type.
module abd_dirty_map #(
   parameter int TILES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  abd_pkg::tile_ctl_type    ctl,
   input  logic [$clog2(TILES)-1:0] addr,
   output logic                     rd_bit,
   output logic                     ready
);
   import abd_pkg::*;

   localparam int AW = $clog2(TILES);

   logic          flag_array [TILES];
   logic [AW-1:0] sweep_ff;
   logic [AW-1:0] sweep_in;
   logic          done_ff;
   logic          done_in;
   logic          rd_bit_ff;

   // walk every entry once after reset
   always_comb begin
      sweep_in = sweep_ff;
      done_in  = done_ff;
      if (!done_ff) begin
         sweep_in = sweep_ff + AW'(1);
         if (sweep_ff == AW'(TILES - 1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         done_ff  <= done_in;
      end
   end

   // sweep owns the write port until done; the user is held off meanwhile
   always_ff @(posedge clock) begin
      if (!done_ff) begin
         flag_array[sweep_ff] <= 1'b1;
      end else if (ctl.en && ctl.we) begin
         flag_array[addr] <= ctl.wbit;
      end
      if (ctl.en) begin
         rd_bit_ff <= flag_array[addr];
      end
   end

   assign rd_bit = rd_bit_ff;
   assign ready  = done_ff;

endmodule

@@ sim/tb.sv @@
// Self-checking bench for arcade_bus_decoder: drives random and directed bus accesses,
// predicts every result from its own copy of ROM, RAM, registers and dirty flags.
// Depends on abd_pkg and the decoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import abd_pkg::*;

   localparam int ROM_BYTES      = ROM_BYTES_DEFAULT;
   localparam int PAGE_BYTES     = PAGE_BYTES_DEFAULT;
   localparam int VRAM_TILES     = VRAM_TILES_DEFAULT;
   localparam int BG_VRAM_OFFSET = BG_VRAM_OFFSET_DEFAULT;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int IDLE_LIMIT     = 4000;   // covers the dirty-map sweep after reset
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 200;

   localparam logic [15:0] RAM_BASE = 16'h4000;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  buttons;
      logic [7:0]  switches;
      logic [7:0]  gap;
      logic        drain;   // hold this item until every result is back
   } access_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       dirty;
      logic       page;
      logic       palette;
      logic [7:0] scroll;
   } bus_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // address[15:0], write_data[23:16],
                                  // button_lines[31:24], switch_lines[39:32]
   logic [1:0]  req_tuser = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // read_data[7:0], dirty_flag[8], page_select[9],
                                  // palette_select[10], scroll_value[18:11], zero above

   arcade_bus_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predicted state of the memory map
   // ---------------------------------------------------------------------------
   logic [7:0]  rom_image [ROM_BYTES];
   logic [7:0]  ram_image [2*PAGE_BYTES];
   bit          tile_dirty [VRAM_TILES] = '{default: 1'b1};
   logic        page_q = 1'b0;
   logic        palette_q = 1'b0;
   logic [7:0]  scroll_q = 8'h00;

   bus_result_type  bus_results_due [$];
   access_item_type pending_items [$];

   int fail_count = 0;
   int taken_count = 0;
   int offered_count = 0;
   int results_seen = 0;
   int idle_cycles = 0;

   // Apply one access to the predicted state and return the result it gives.
   function automatic bus_result_type decode_access(mode_type mode, logic [15:0] addr,
                                                    logic [7:0] wdata, logic [7:0] buttons,
                                                    logic [7:0] switches);
      bus_result_type res;
      int             off;
      res.read_data = UNMAPPED_BYTE;
      res.dirty     = 1'b0;
      off           = int'(addr) - int'(RAM_BASE);
      case (mode)
         MODE_READ: begin
            if (addr < 16'h4000)
               res.read_data = (int'(addr) < ROM_BYTES) ? rom_image[addr] : UNMAPPED_BYTE;
            else if (addr[15:12] == WIN_RAM)
               res.read_data = (off < PAGE_BYTES) ? ram_image[page_q*PAGE_BYTES + off]
                                                   : UNMAPPED_BYTE;
            else if (addr[15:11] == WIN_BUTTONS)
               res.read_data = buttons;
            else if (addr[15:11] == WIN_SWITCH)
               res.read_data = switches;
         end
         MODE_WRITE: begin
            if (addr[15:12] == WIN_RAM) begin
               if (off < PAGE_BYTES) begin
                  ram_image[page_q*PAGE_BYTES + off] = wdata;
                  if (off >= BG_VRAM_OFFSET && off < BG_VRAM_OFFSET + VRAM_TILES)
                     tile_dirty[off - BG_VRAM_OFFSET] = 1'b1;
               end
            end else if (addr[15:11] == WIN_VIDEO) begin
               page_q    = wdata[0];
               palette_q = wdata[1];
            end else if (addr[15:11] == WIN_SCROLL) begin
               scroll_q = wdata;
            end
         end
         MODE_LOAD: begin
            if (int'(addr) < ROM_BYTES)
               rom_image[addr] = wdata;
         end
         MODE_TAKE: begin
            if (int'(addr) < VRAM_TILES) begin
               res.dirty = tile_dirty[addr];
               tile_dirty[addr] = 1'b0;
            end
         end
      endcase
      res.page    = page_q;
      res.palette = palette_q;
      res.scroll  = scroll_q;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus bookkeeping: never read a ROM or RAM byte that was not written
   // ---------------------------------------------------------------------------
   bit rom_loaded [ROM_BYTES];
   bit ram_written [2*PAGE_BYTES];
   int rom_loaded_list [$];
   int ram_offs_page0 [$];
   int ram_offs_page1 [$];
   bit gen_page = 1'b0;
   int burst_left = 0;

   task automatic add_item(mode_type mode, logic [15:0] addr, logic [7:0] wdata, bit drain);
      access_item_type it;
      int              r;
      int              idx;
      it.mode     = mode;
      it.addr     = addr;
      it.wdata    = wdata;
      it.buttons  = 8'($urandom_range(0, 255));
      it.switches = 8'($urandom_range(0, 255));
      it.drain    = drain;
      // most gaps short, a few long, none inside a burst
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         it.gap = '0;
      end else if (r < 60)
         it.gap = '0;
      else if (r < 90)
         it.gap = 8'($urandom_range(1, 3));
      else if (r < 98)
         it.gap = 8'($urandom_range(4, 10));
      else
         it.gap = 8'($urandom_range(20, 60));
      if (mode == MODE_LOAD && int'(addr) < ROM_BYTES && !rom_loaded[addr]) begin
         rom_loaded[addr] = 1'b1;
         rom_loaded_list.push_back(int'(addr));
      end
      if (mode == MODE_WRITE && addr[15:12] == WIN_RAM) begin
         idx = gen_page*PAGE_BYTES + int'(addr) - int'(RAM_BASE);
         if (!ram_written[idx]) begin
            ram_written[idx] = 1'b1;
            if (gen_page)
               ram_offs_page1.push_back(int'(addr) - int'(RAM_BASE));
            else
               ram_offs_page0.push_back(int'(addr) - int'(RAM_BASE));
         end
      end
      if (mode == MODE_WRITE && addr[15:11] == WIN_VIDEO)
         gen_page = wdata[0];
      pending_items.push_back(it);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: present items at the falling edge, advance once one is taken
   // ---------------------------------------------------------------------------
   access_item_type staged_item;
   bit              have_staged = 1'b0;
   int              gap_left = 0;

   always @(negedge clock) begin
      // hold the item on the bus until it has been taken
      if (!reset && !(req_tvalid && taken_count != offered_count)) begin
         if (!have_staged && pending_items.size() != 0) begin
            staged_item = pending_items.pop_front();
            have_staged = 1'b1;
            gap_left    = staged_item.gap;
         end
         if (have_staged && gap_left == 0 &&
             (!staged_item.drain || bus_results_due.size() == 0)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= staged_item.mode;
            req_tdata  <= {staged_item.switches, staged_item.buttons,
                           staged_item.wdata, staged_item.addr};
            have_staged = 1'b0;
            offered_count++;
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver pacing: random stalls, calm stretches, and one long hold-off
   // while the sender keeps offering, so the block backs up into req_tready
   // ---------------------------------------------------------------------------
   int  hold_left = 0;
   int  calm_left = 0;
   bit  long_hold_done = 1'b0;
   int  pace_roll;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 600) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_tready    <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else begin
         pace_roll = $urandom_range(0, 99);
         if (pace_roll < 3) begin
            calm_left   = 80;
            rsp_tready <= 1'b1;
         end else if (pace_roll < 15) begin
            hold_left   = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else if (pace_roll < 16) begin
            hold_left   = $urandom_range(20, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: at the rising edge predict each taken item, check each result
   // against the oldest prediction, and watch for a stuck handshake
   // ---------------------------------------------------------------------------
   bus_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (bus_results_due.size() == 0) begin
            $error("unexpected result %h with nothing outstanding", rsp_tdata);
            fail_count++;
         end else begin
            want = bus_results_due.pop_front();
            check_field("read_data", 32'(want.read_data), 32'(rsp_tdata[7:0]));
            check_field("dirty_flag", 32'(want.dirty), 32'(rsp_tdata[8]));
            check_field("page_select", 32'(want.page), 32'(rsp_tdata[9]));
            check_field("palette_select", 32'(want.palette), 32'(rsp_tdata[10]));
            check_field("scroll_value", 32'(want.scroll), 32'(rsp_tdata[18:11]));
            check_field("tdata_pad", '0, 32'(rsp_tdata[23:19]));
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         taken_count++;
         bus_results_due.push_back(decode_access(mode_type'(req_tuser), req_tdata[15:0],
                                                 req_tdata[23:16], req_tdata[31:24],
                                                 req_tdata[39:32]));
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus: directed corners first, then a weighted random mix
   // ---------------------------------------------------------------------------
   initial begin
      logic [15:0] odd_reads [6];
      int          r;
      int          addr;
      int          off;
      bit          drain;

      odd_reads = '{16'h6000, 16'h7000, 16'h77FF, 16'h7800, 16'h8000, 16'hFFFF};

      // ROM bounds, a load past the ROM, and a bus write that must not reach ROM
      add_item(MODE_LOAD, 16'h0000, 8'h00, 1'b0);
      add_item(MODE_LOAD, 16'h3FFF, 8'hFF, 1'b0);
      add_item(MODE_LOAD, 16'hFFFF, 8'h5A, 1'b0);
      add_item(MODE_WRITE, 16'h0000, 8'hAA, 1'b0);
      add_item(MODE_READ, 16'h0000, 8'h00, 1'b0);
      add_item(MODE_READ, 16'h3FFF, 8'h00, 1'b0);
      // RAM bounds on the page that reset selects
      add_item(MODE_WRITE, 16'h4000, 8'h11, 1'b0);
      add_item(MODE_WRITE, 16'h4FFF, 8'hEE, 1'b0);
      add_item(MODE_READ, 16'h4FFF, 8'h00, 1'b0);
      // dirty flags: set after reset, cleared by a take, set again by a VRAM write
      add_item(MODE_TAKE, 16'h0000, 8'h00, 1'b0);
      add_item(MODE_TAKE, 16'h0000, 8'h00, 1'b0);
      add_item(MODE_WRITE, 16'h4800, 8'h77, 1'b0);
      add_item(MODE_TAKE, 16'h0000, 8'h00, 1'b0);
      add_item(MODE_TAKE, 16'h03FF, 8'h00, 1'b0);
      add_item(MODE_TAKE, 16'h0400, 8'h00, 1'b0);
      // page and palette through the video register, both ends of its window
      add_item(MODE_WRITE, 16'h5000, 8'h03, 1'b0);
      add_item(MODE_WRITE, 16'h4000, 8'h22, 1'b0);
      add_item(MODE_READ, 16'h4000, 8'h00, 1'b0);
      add_item(MODE_WRITE, 16'h57FF, 8'h00, 1'b0);
      add_item(MODE_READ, 16'h4000, 8'h00, 1'b0);
      // scroll register, then ignored writes to sound and high memory
      add_item(MODE_WRITE, 16'h5800, 8'hA5, 1'b0);
      add_item(MODE_WRITE, 16'h5FFF, 8'hFF, 1'b0);
      add_item(MODE_WRITE, 16'h6000, 8'h33, 1'b0);
      add_item(MODE_WRITE, 16'hFFFF, 8'h55, 1'b0);
      foreach (odd_reads[i])
         add_item(MODE_READ, odd_reads[i], 8'h00, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // the first random item and a few more wait for the block to drain
         drain = (n == 0) || ($urandom_range(0, 249) == 0);
         if (burst_left == 0 && $urandom_range(0, 49) == 0)
            burst_left = $urandom_range(30, 100);
         r = $urandom_range(0, 99);
         // fall back to a ROM load or a RAM write when nothing readable exists yet
         if (r >= 18 && r < 33 && rom_loaded_list.size() == 0)
            r = 0;
         if (r >= 48 && r < 62 &&
             (gen_page ? ram_offs_page1.size() : ram_offs_page0.size()) == 0)
            r = 33;
         if (r < 18) begin
            addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, ROM_BYTES - 1);
            add_item(MODE_LOAD, 16'(addr), 8'($urandom_range(0, 255)), drain);
         end else if (r < 33) begin
            addr = rom_loaded_list[$urandom_range(0, rom_loaded_list.size() - 1)];
            add_item(MODE_READ, 16'(addr), 8'($urandom_range(0, 255)), drain);
         end else if (r < 48) begin
            // half of the RAM writes land on the first few background tiles
            off = $urandom_range(0, 1) ? BG_VRAM_OFFSET + $urandom_range(0, 31)
                                       : $urandom_range(0, PAGE_BYTES - 1);
            add_item(MODE_WRITE, 16'(int'(RAM_BASE) + off), 8'($urandom_range(0, 255)),
                     drain);
         end else if (r < 62) begin
            off = gen_page ? ram_offs_page1[$urandom_range(0, ram_offs_page1.size() - 1)]
                           : ram_offs_page0[$urandom_range(0, ram_offs_page0.size() - 1)];
            add_item(MODE_READ, 16'(int'(RAM_BASE) + off), 8'($urandom_range(0, 255)),
                     drain);
         end else if (r < 67) begin
            add_item(MODE_WRITE, 16'(16'h5000 + $urandom_range(0, 16'h07FF)),
                     8'($urandom_range(0, 255)), drain);
         end else if (r < 71) begin
            add_item(MODE_WRITE, 16'(16'h5800 + $urandom_range(0, 16'h07FF)),
                     8'($urandom_range(0, 255)), drain);
         end else if (r < 80) begin
            r = $urandom_range(0, 99);
            addr = (r < 50) ? $urandom_range(0, 31)
                 : (r < 85) ? $urandom_range(0, VRAM_TILES - 1)
                 : $urandom_range(0, 65535);
            add_item(MODE_TAKE, 16'(addr), 8'($urandom_range(0, 255)), drain);
         end else if (r < 88) begin
            add_item(MODE_READ, 16'(16'h7000 + $urandom_range(0, 16'h0FFF)),
                     8'($urandom_range(0, 255)), drain);
         end else if (r < 94) begin
            addr = $urandom_range(0, 1) ? 16'h5000 + $urandom_range(0, 16'h1FFF)
                                        : 16'h8000 + $urandom_range(0, 16'h7FFF);
            add_item(MODE_READ, 16'(addr), 8'($urandom_range(0, 255)), drain);
         end else begin
            // writes that change nothing: ROM, sound, inputs, high memory
            r = $urandom_range(0, 3);
            addr = (r == 0) ? $urandom_range(0, 16'h3FFF)
                 : (r == 1) ? 16'h6000 + $urandom_range(0, 16'h0FFF)
                 : (r == 2) ? 16'h7000 + $urandom_range(0, 16'h0FFF)
                 : 16'h8000 + $urandom_range(0, 16'h7FFF);
            add_item(MODE_WRITE, 16'(addr), 8'($urandom_range(0, 255)), drain);
         end
      end

      // hold reset, then release it at a falling edge
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // wait until every item is taken and every result is back, then settle
      while (pending_items.size() != 0 || have_staged || taken_count != offered_count ||
             bus_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/abd_pkg.sv
hdl/abd_spram.sv
hdl/abd_dirty_map.sv
hdl/arcade_bus_decoder.sv
sim/tb.sv
